// ===== rtl/core/kvhc_pkg.sv =====
package kvhc_pkg;

   localparam logic [7:0]  REQ_MAGIC          = 8'h80;
   localparam logic [7:0]  OPC_LAST           = 8'h1A;
   localparam logic [15:0] MAX_KEY_LENGTH_RST = 16'd250;

   localparam logic [3:0] OP_GET     = 4'd0;
   localparam logic [3:0] OP_SET     = 4'd1;
   localparam logic [3:0] OP_ADD     = 4'd2;
   localparam logic [3:0] OP_REPLACE = 4'd3;
   localparam logic [3:0] OP_DELETE  = 4'd4;
   localparam logic [3:0] OP_INCR    = 4'd5;
   localparam logic [3:0] OP_DECR    = 4'd6;
   localparam logic [3:0] OP_QUIT    = 4'd7;
   localparam logic [3:0] OP_FLUSH   = 4'd8;
   localparam logic [3:0] OP_NOOP    = 4'd9;
   localparam logic [3:0] OP_VERSION = 4'd10;
   localparam logic [3:0] OP_APPEND  = 4'd11;
   localparam logic [3:0] OP_PREPEND = 4'd12;
   localparam logic [3:0] OP_STATE   = 4'd13;

   localparam logic [3:0] ERR_OK        = 4'd0;
   localparam logic [3:0] ERR_MAGIC     = 4'd1;
   localparam logic [3:0] ERR_OPCODE    = 4'd2;
   localparam logic [3:0] ERR_KEY_FORB  = 4'd3;
   localparam logic [3:0] ERR_KEY_LONG  = 4'd4;
   localparam logic [3:0] ERR_EXTRAS    = 4'd5;
   localparam logic [3:0] ERR_DATATYPE  = 4'd6;
   localparam logic [3:0] ERR_RESERVED  = 4'd7;
   localparam logic [3:0] ERR_SHORT     = 4'd8;
   localparam logic [3:0] ERR_VAL_FORB  = 4'd9;

   localparam logic [7:0] EXTRAS_GET   = 8'd4;
   localparam logic [7:0] EXTRAS_STORE = 8'd8;
   localparam logic [7:0] EXTRAS_ARITH = 8'd20;
   localparam logic [7:0] EXTRAS_NONE  = 8'd0;

   typedef struct packed {
      logic [7:0]  magic;
      logic [7:0]  opcode;
      logic [15:0] key_length;
      logic [7:0]  extras_length;
      logic [7:0]  data_type;
      logic [15:0] reserved_word;
      logic [31:0] total_body_length;
      logic [31:0] opaque;
      logic [63:0] cas;
   } kvhc_header_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic [3:0]  operation;
      logic        quiet;
      logic        return_key;
      logic [31:0] value_length;
      logic [31:0] opaque;
      logic [63:0] cas;
   } kvhc_result_type;

   typedef struct packed {
      logic       return_key;
      logic       quiet;
      logic [3:0] operation;
   } kvhc_opc_type;

   function automatic kvhc_opc_type opc_map(input logic [7:0] opc);
      kvhc_opc_type m;
      m = '{return_key: 1'b0, quiet: 1'b0, operation: OP_GET};
      case (opc)
         8'h00: m.operation = OP_GET;
         8'h01: m.operation = OP_SET;
         8'h02: m.operation = OP_ADD;
         8'h03: m.operation = OP_REPLACE;
         8'h04: m.operation = OP_DELETE;
         8'h05: m.operation = OP_INCR;
         8'h06: m.operation = OP_DECR;
         8'h07: m.operation = OP_QUIT;
         8'h08: m.operation = OP_FLUSH;
         8'h09: begin
            m.operation = OP_GET;
            m.quiet     = 1'b1;
         end
         8'h0A: m.operation = OP_NOOP;
         8'h0B: m.operation = OP_VERSION;
         8'h0C: begin
            m.operation  = OP_GET;
            m.return_key = 1'b1;
         end
         8'h0D: begin
            m.operation  = OP_GET;
            m.quiet      = 1'b1;
            m.return_key = 1'b1;
         end
         8'h0E: m.operation = OP_APPEND;
         8'h0F: m.operation = OP_PREPEND;
         8'h10: m.operation = OP_STATE;
         8'h11: begin
            m.operation = OP_SET;
            m.quiet     = 1'b1;
         end
         8'h12: begin
            m.operation = OP_ADD;
            m.quiet     = 1'b1;
         end
         8'h13: begin
            m.operation = OP_REPLACE;
            m.quiet     = 1'b1;
         end
         8'h14: begin
            m.operation = OP_DELETE;
            m.quiet     = 1'b1;
         end
         8'h15: begin
            m.operation = OP_INCR;
            m.quiet     = 1'b1;
         end
         8'h16: begin
            m.operation = OP_DECR;
            m.quiet     = 1'b1;
         end
         8'h17: begin
            m.operation = OP_QUIT;
            m.quiet     = 1'b1;
         end
         8'h18: begin
            m.operation = OP_FLUSH;
            m.quiet     = 1'b1;
         end
         8'h19: begin
            m.operation = OP_APPEND;
            m.quiet     = 1'b1;
         end
         8'h1A: begin
            m.operation = OP_PREPEND;
            m.quiet     = 1'b1;
         end
         default: m = '{return_key: 1'b0, quiet: 1'b0, operation: OP_GET};
      endcase
      return m;
   endfunction

   function automatic logic [7:0] need_extras(input logic [3:0] op);
      logic [7:0] n;
      case (op)
         OP_GET:                         n = EXTRAS_GET;
         OP_SET, OP_ADD, OP_REPLACE:     n = EXTRAS_STORE;
         OP_INCR, OP_DECR:               n = EXTRAS_ARITH;
         default:                        n = EXTRAS_NONE;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/kvhc_csr.sv =====
module kvhc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_key_length,
   output logic [15:0] max_key_length
);
   import kvhc_pkg::*;

   logic [15:0] max_key_ff;
   logic [15:0] max_key_in;

   assign csr_ready = 1'b1;

   always_comb begin
      max_key_in = max_key_ff;
      if (csr_valid) begin
         max_key_in = csr_max_key_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_key_ff <= MAX_KEY_LENGTH_RST;
      end else begin
         max_key_ff <= max_key_in;
      end
   end

   assign max_key_length = max_key_ff;

endmodule

// ===== rtl/core/kvhc_check.sv =====
module kvhc_check (
   input  kvhc_pkg::kvhc_header_type hdr,
   input  logic [15:0]               max_key_length,
   output kvhc_pkg::kvhc_result_type res
);
   import kvhc_pkg::*;

   kvhc_opc_type m;
   logic         no_key;
   logic         may_value;
   logic [16:0]  head_len;
   logic [31:0]  vlen;

   always_comb begin
      m         = opc_map(hdr.opcode);
      no_key    = (m.operation == OP_QUIT) || (m.operation == OP_FLUSH) ||
                  (m.operation == OP_NOOP) || (m.operation == OP_VERSION);
      may_value = (m.operation == OP_SET) || (m.operation == OP_ADD) ||
                  (m.operation == OP_REPLACE) || (m.operation == OP_APPEND) ||
                  (m.operation == OP_PREPEND);
      head_len  = {1'b0, hdr.key_length} + {9'd0, hdr.extras_length};
      vlen      = hdr.total_body_length - {15'd0, head_len};

      res.opaque       = hdr.opaque;
      res.cas          = hdr.cas;
      res.operation    = m.operation;
      res.quiet        = m.quiet;
      res.return_key   = m.return_key;
      res.value_length = 32'd0;
      res.error_code   = ERR_OK;

      if (hdr.magic != REQ_MAGIC) begin
         res.error_code = ERR_MAGIC;
      end else if (hdr.opcode > OPC_LAST) begin
         res.error_code = ERR_OPCODE;
      end else if (no_key && (hdr.key_length != 16'd0)) begin
         res.error_code = ERR_KEY_FORB;
      end else if (!no_key && (hdr.key_length > max_key_length)) begin
         res.error_code = ERR_KEY_LONG;
      end else if (hdr.extras_length != need_extras(m.operation)) begin
         res.error_code = ERR_EXTRAS;
      end else if (hdr.data_type != 8'd0) begin
         res.error_code = ERR_DATATYPE;
      end else if (hdr.reserved_word != 16'd0) begin
         res.error_code = ERR_RESERVED;
      end else if (hdr.total_body_length < {15'd0, head_len}) begin
         res.error_code = ERR_SHORT;
      end else if (!may_value && (vlen != 32'd0)) begin
         res.error_code = ERR_VAL_FORB;
      end else begin
         res.value_length = vlen;
      end

      // drop the decode when the opcode was never reached
      if ((res.error_code == ERR_MAGIC) || (res.error_code == ERR_OPCODE)) begin
         res.operation  = OP_GET;
         res.quiet      = 1'b0;
         res.return_key = 1'b0;
      end
   end

endmodule

// ===== rtl/core/kv_request_header_check.sv =====
// Binary key-value request header check.
// Request channel: req_valid/req_ready with one request header per item.
// Response channel: rsp_valid/rsp_ready with the verdict, decoded operation,
// quiet and return-key flags, value length and the copied opaque and cas.
// Control port: csr_valid/csr_ready writes max_key_length; csr_ready is
// always high. Write it only while no item is in flight.
// Flow: an accepted item lands in the input register, is judged and
// captured in the result register once that register is free or is
// being drained, and rsp_valid then rises.
// Throughput: one item per cycle while the output is not stalled, set by
// the single check pass between the input register and the result register.
// Reset: both pipeline registers empty, max_key_length returns to 250.
// Stall: while rsp_ready is low the result holds; one more item is taken
// into the input register, then req_ready drops until the result leaves.
module kv_request_header_check (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_magic,
   input  logic [7:0]  req_opcode,
   input  logic [15:0] req_key_length,
   input  logic [7:0]  req_extras_length,
   input  logic [7:0]  req_data_type,
   input  logic [15:0] req_reserved_word,
   input  logic [31:0] req_total_body_length,
   input  logic [31:0] req_opaque_in,
   input  logic [63:0] req_cas_in,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_error_code,
   output logic [3:0]  rsp_operation,
   output logic        rsp_quiet,
   output logic        rsp_return_key,
   output logic [31:0] rsp_value_length,
   output logic [31:0] rsp_opaque_out,
   output logic [63:0] rsp_cas_out,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_key_length
);
   import kvhc_pkg::*;

   logic            hdr_valid_ff;
   logic            hdr_valid_in;
   kvhc_header_type hdr_ff;
   kvhc_header_type hdr_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   kvhc_result_type res_ff;
   kvhc_result_type res_comb;
   logic            advance;
   logic            req_take;
   logic [15:0]     max_key_length;

   kvhc_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_key_length (csr_max_key_length),
      .max_key_length     (max_key_length)
   );

   kvhc_check u_check (
      .hdr            (hdr_ff),
      .max_key_length (max_key_length),
      .res            (res_comb)
   );

   assign advance   = hdr_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !hdr_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      hdr_in.magic             = req_magic;
      hdr_in.opcode            = req_opcode;
      hdr_in.key_length        = req_key_length;
      hdr_in.extras_length     = req_extras_length;
      hdr_in.data_type         = req_data_type;
      hdr_in.reserved_word     = req_reserved_word;
      hdr_in.total_body_length = req_total_body_length;
      hdr_in.opaque            = req_opaque_in;
      hdr_in.cas               = req_cas_in;

      hdr_valid_in = req_take || (hdr_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_valid_ff <= hdr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hdr_ff <= hdr_in;
      end
      if (advance) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error_code   = res_ff.error_code;
   assign rsp_operation    = res_ff.operation;
   assign rsp_quiet        = res_ff.quiet;
   assign rsp_return_key   = res_ff.return_key;
   assign rsp_value_length = res_ff.value_length;
   assign rsp_opaque_out   = res_ff.opaque;
   assign rsp_cas_out      = res_ff.cas;

   a_vlen_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (res_ff.error_code != ERR_OK)) |-> (res_ff.value_length == 32'd0))
      else $error("value length not zero on error");

   a_no_decode_early_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((res_ff.error_code == ERR_MAGIC) ||
                        (res_ff.error_code == ERR_OPCODE)))
      |-> ((res_ff.operation == OP_GET) && !res_ff.quiet && !res_ff.return_key))
      else $error("decode fields set on magic or opcode error");

   a_stall_only_on_output: assert property (@(posedge clock) disable iff (reset)
      (hdr_valid_ff && !advance) |-> (rsp_valid_ff && !rsp_ready))
      else $error("input register stalled without output backpressure");

   a_result_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(res_ff)))
      else $error("result changed while stalled");

   a_return_key_is_get: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.return_key) |-> (res_ff.operation == OP_GET))
      else $error("return key on non-get operation");

endmodule
